/* hw/rtl/mae_pkg.sv */
// Shared types and constants for the mobile allocation encoder.
// Used by the lane, merge and top-level modules; depends on nothing else.
package mae_pkg;

  // Bitmap capacity limits and the channel range that is looked at.
  localparam int MAX_MA_BITS  = 64;
  localparam int NUM_CHANNELS = 1024;
  localparam int BITMAP_CAP   = (MAX_MA_BITS < 64) ? MAX_MA_BITS : 64;

  // One input word is split over this many lanes of this many bits.
  localparam int WORD_W    = 64;
  localparam int LANE_W    = 8;
  localparam int NUM_LANES = WORD_W / LANE_W;
  localparam int WORDS_PER_RUN = 16;

  // Bits of the bitmap below the capacity.
  localparam logic [WORD_W-1:0] CAP_MASK =
    (BITMAP_CAP >= WORD_W) ? {WORD_W{1'b1}} :
    ((64'd1 << BITMAP_CAP) - 64'd1);

  // What one lane found in its slice of a word.
  typedef struct packed {
    logic [3:0]        cnt;
    logic [LANE_W-1:0] bits;
  } lane_res_t;

  // Bitmap being built for the current run.
  typedef struct packed {
    logic [WORD_W-1:0] ma_bits;
    logic [6:0]        cell_count;
    logic              overflowed;
  } map_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_CH0,
    ST_EMIT
  } state_t;

endpackage

/* hw/rtl/mae_lane.sv */
// One lane: counts the cell channels in an 8-bit slice and packs their
// hopping bits toward the low end. Depends on mae_pkg.
module mae_lane
  import mae_pkg::*;
(
  input  logic [LANE_W-1:0] cell_i,
  input  logic [LANE_W-1:0] hop_i,
  output lane_res_t         res_o
);

  logic [3:0]        cnt;
  logic [LANE_W-1:0] packed_bits;

  // Walk the slice, placing each cell channel's hop bit at its rank.
  always_comb begin
    cnt         = 4'd0;
    packed_bits = '0;
    for (int m = 0; m < LANE_W; m++) begin
      if (cell_i[m]) begin
        packed_bits[cnt[2:0]] = hop_i[m];
        cnt = cnt + 4'd1;
      end
    end
  end

  assign res_o.cnt  = cnt;
  assign res_o.bits = packed_bits;

endmodule

/* hw/rtl/mae_merge.sv */
// Merging stage: lays the packed lane bits into the bitmap at their running
// offsets and clips at the bitmap capacity. Depends on mae_pkg.
module mae_merge
  import mae_pkg::*;
(
  input  lane_res_t  lanes_i [NUM_LANES],
  input  map_state_t st_i,
  output map_state_t st_o
);

  logic [7:0]        pos;
  logic [WORD_W-1:0] acc;

  // Running offset of each lane, starting at the current fill.
  always_comb begin
    pos = {1'b0, st_i.cell_count};
    acc = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (pos < 8'(WORD_W)) begin
        acc = acc | (WORD_W'(lanes_i[i].bits) << pos[5:0]);
      end
      pos = pos + 8'(lanes_i[i].cnt);
    end
  end

  // Channels past the capacity are dropped and flagged.
  always_comb begin
    st_o.ma_bits = st_i.ma_bits | (acc & CAP_MASK);
    if (pos > 8'(BITMAP_CAP)) begin
      st_o.cell_count = 7'(BITMAP_CAP);
      st_o.overflowed = 1'b1;
    end else begin
      st_o.cell_count = pos[6:0];
      st_o.overflowed = st_i.overflowed;
    end
  end

endmodule

/* hw/rtl/mobile_allocation_encoder.sv */
// Top level of the mobile allocation encoder: input masking, lane array,
// merge stage and octet output sequencer. Depends on mae_pkg, mae_lane, mae_merge.
//
// A run is a series of 64-bit words (cell allocation plus hopping set) given
// with start while busy is low; the word with in_last_word set ends the run.
// Words that are not last are taken every cycle: eight lanes count and pack
// a word, the lane results are registered, and the merge stage adds them to
// the bitmap register. After the last word busy stays high through the merge
// state, the state that places channel 0, and one result word per octet, 1 to
// 8 of them (a single empty word if hopping is off or no cell is set). Results
// appear on the out_ ports for exactly one cycle each, marked by out_valid;
// the receiver cannot stall them. cfg_we/cfg_wdata set hopping_enabled,
// which is sampled when the run's octets are produced.
module mobile_allocation_encoder
  import mae_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_cell_word,
  input  logic [63:0] in_hop_word,
  input  logic        in_last_word,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output logic        out_valid,
  output logic [7:0]  out_ma_octet,
  output logic [2:0]  out_octet_index,
  output logic [3:0]  out_ma_length,
  output logic        out_overflow,
  output logic        out_last_octet
);

  state_t     state_r, state_nxt;
  logic       hop_en_r;
  logic [4:0] word_pos_r, word_pos_nxt;
  logic       chan0_cell_r, chan0_cell_nxt;
  logic       chan0_hop_r, chan0_hop_nxt;
  logic       lane_valid_r;
  lane_res_t  lane_r   [NUM_LANES];
  lane_res_t  lane_nxt [NUM_LANES];
  map_state_t map_r, map_nxt, map_merged;
  logic [2:0] idx_r, idx_nxt;

  logic              accept;
  logic [WORD_W-1:0] cell_masked;
  logic [9:0]        chan;
  logic [3:0]        len;
  logic              empty_run;
  logic              emit_done;
  logic [2:0]        byte_sel;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_octet_r, out_octet_nxt;
  logic [2:0] out_index_r, out_index_nxt;
  logic [3:0] out_len_r, out_len_nxt;
  logic       out_ovf_r, out_ovf_nxt;
  logic       out_last_r, out_last_nxt;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Keep only cell channels in range; channel 0 is held back for the end.
  always_comb begin
    chan = '0;
    for (int b = 0; b < WORD_W; b++) begin
      chan = {word_pos_r[3:0], 6'(b)};
      cell_masked[b] = in_cell_word[b] && !word_pos_r[4] &&
                       (11'(chan) < 11'(NUM_CHANNELS)) && (chan != 10'd0);
    end
  end

  // Lane array.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    mae_lane u_lane (
      .cell_i (cell_masked[g*LANE_W +: LANE_W]),
      .hop_i  (in_hop_word[g*LANE_W +: LANE_W]),
      .res_o  (lane_nxt[g])
    );
  end

  // Merge of the registered lane results into the bitmap.
  mae_merge u_merge (
    .lanes_i (lane_r),
    .st_i    (map_r),
    .st_o    (map_merged)
  );

  // Length and byte selection for the output octets.
  assign len       = 4'((8'(map_r.cell_count) + 8'd7) >> 3);
  assign empty_run = !hop_en_r || (len == 4'd0);
  assign emit_done = empty_run || ({1'b0, idx_r} == (len - 4'd1));
  assign byte_sel  = 3'(len - 4'd1 - {1'b0, idx_r});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept && in_last_word) state_nxt = ST_MERGE;
      ST_MERGE: state_nxt = ST_CH0;
      ST_CH0:   state_nxt = ST_EMIT;
      ST_EMIT:  if (emit_done) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Result word for the next cycle.
  always_comb begin
    out_valid_nxt = 1'b0;
    out_octet_nxt = 8'd0;
    out_index_nxt = 3'd0;
    out_len_nxt   = 4'd0;
    out_ovf_nxt   = 1'b0;
    out_last_nxt  = 1'b0;
    case (state_r)
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        if (empty_run) begin
          out_last_nxt = 1'b1;
        end else begin
          out_octet_nxt = map_r.ma_bits[{byte_sel, 3'b000} +: 8];
          out_index_nxt = idx_r;
          out_len_nxt   = len;
          out_ovf_nxt   = map_r.overflowed;
          out_last_nxt  = emit_done;
        end
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  // Run state: word position, channel 0, bitmap and octet counter.
  always_comb begin
    word_pos_nxt   = word_pos_r;
    chan0_cell_nxt = chan0_cell_r;
    chan0_hop_nxt  = chan0_hop_r;
    map_nxt        = map_r;
    idx_nxt        = idx_r;
    if (accept) begin
      if (!word_pos_r[4]) word_pos_nxt = word_pos_r + 5'd1;
      if (word_pos_r == 5'd0 && in_cell_word[0]) begin
        chan0_cell_nxt = 1'b1;
        chan0_hop_nxt  = in_hop_word[0];
      end
    end
    if (lane_valid_r) map_nxt = map_merged;
    if (state_r == ST_CH0 && chan0_cell_r) begin
      if (map_r.cell_count >= 7'(BITMAP_CAP)) begin
        map_nxt.overflowed = 1'b1;
      end else begin
        map_nxt.ma_bits[map_r.cell_count[5:0]] = chan0_hop_r;
        map_nxt.cell_count = map_r.cell_count + 7'd1;
      end
    end
    if (state_r == ST_EMIT) begin
      idx_nxt = idx_r + 3'd1;
      if (emit_done) begin
        word_pos_nxt   = '0;
        chan0_cell_nxt = 1'b0;
        chan0_hop_nxt  = 1'b0;
        map_nxt        = '0;
        idx_nxt        = '0;
      end
    end
  end

  // Control and run registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hop_en_r     <= 1'b0;
      word_pos_r   <= '0;
      chan0_cell_r <= 1'b0;
      chan0_hop_r  <= 1'b0;
      lane_valid_r <= 1'b0;
      map_r        <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_we) hop_en_r <= cfg_wdata;
      word_pos_r   <= word_pos_nxt;
      chan0_cell_r <= chan0_cell_nxt;
      chan0_hop_r  <= chan0_hop_nxt;
      lane_valid_r <= accept;
      map_r        <= map_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) lane_r <= lane_nxt;
    out_octet_r <= out_octet_nxt;
    out_index_r <= out_index_nxt;
    out_len_r   <= out_len_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ma_octet    = out_octet_r;
  assign out_octet_index = out_index_r;
  assign out_ma_length   = out_len_r;
  assign out_overflow    = out_ovf_r;
  assign out_last_octet  = out_last_r;

`ifndef SYNTH
  // The bitmap fill never passes the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    map_r.cell_count <= 7'(BITMAP_CAP))
    else $error("cell count above bitmap capacity");

  // A result word only follows an output-sequencer cycle.
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_EMIT))
    else $error("result word outside the output phase");

  // The last word of a run makes the block busy at once.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_word) |=> busy)
    else $error("not busy after the last word");

  // No result word comes right after the final octet of a run.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_octet) |=> !out_valid)
    else $error("result word right after the final octet");

  // Lane results are merged only for an accepted word.
  a_lane_src: assert property (@(posedge clk) disable iff (!rst_n)
    lane_valid_r |-> $past(start && !busy))
    else $error("lane results without an accepted word");
`endif

endmodule
